>>> sv/pmt_pkg.sv
// Package for the bus page map translator: widths, operation codes,
// configuration register indexes and parameter defaults.
// No dependencies.
`default_nettype none

package pmt_pkg;

    // Fixed field widths of one item.
    localparam int OPCODE_W = 2;
    localparam int BUS_W    = 18;
    localparam int HALF_W   = 16;
    localparam int OFFSET_W = 13;
    localparam int SEL_W    = 5;

    // Operation codes.
    localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_XLATE = 2'd2;

    // When mapping is enabled, the topmost bus page maps to the I/O page base.
    localparam logic [SEL_W-1:0] TOP_PAGE = 5'd31;

    // Mask applied to the high half on a map read (six bits).
    localparam logic [HALF_W-1:0] HIGH_READ_MASK = 16'h003F;

    // Configuration port.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IO_PAGE_BASE = 2'd1;

    // Parameter defaults and reset values.
    localparam int MAP_ENTRIES_DEF    = 32;
    localparam int PHYS_ADDR_BITS_DEF = 22;
    localparam logic [31:0] IO_PAGE_BASE_RST = 32'd4186112;

endpackage

`default_nettype wire

>>> sv/pmt_if.sv
// Handshake interfaces for the bus page map translator: the request
// channel and the result channel. Depends on pmt_pkg.
`default_nettype none

interface pmt_in_if
    import pmt_pkg::*;
    ();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [BUS_W-1:0]    bus_address;
    logic [HALF_W-1:0]   write_data;

    modport source (output valid, opcode, bus_address, write_data, input ready);
    modport sink   (input valid, opcode, bus_address, write_data, output ready);
endinterface

interface pmt_out_if
    import pmt_pkg::*;
    #(
    parameter int PHYS_ADDR_BITS = PHYS_ADDR_BITS_DEF
    );
    logic                      valid;
    logic                      ready;
    logic [HALF_W-1:0]         read_data;
    logic [PHYS_ADDR_BITS-1:0] physical_address;

    modport source (output valid, read_data, physical_address, input ready);
    modport sink   (input valid, read_data, physical_address, output ready);
endinterface

`default_nettype wire

>>> sv/bus_page_map_translator.sv
// Top level of the bus page map translator: map register store, request
// stage and result stage. Depends on pmt_pkg and the interfaces in pmt_if.
`default_nettype none

// The translator accepts one item per clock cycle while the result side keeps
// taking items. The first stage captures the request and reads the map store,
// whose read data is registered; the second stage picks the base, adds the
// page offset and loads the result register. A map write updates the store at
// the edge where it is accepted, so an item accepted in the very next cycle
// already sees the new value. The store is kept as two memories, one for the
// 16-bit low half and one for the high half, so that a half write never needs
// the other half. Each half of each entry has a valid bit that reset clears at
// once; an entry half never written reads as zero, so no clearing pass follows
// reset. Configuration writes (map enable and the I/O page base) must only be
// made while the block is idle.
module bus_page_map_translator
    import pmt_pkg::*;
    #(
    parameter int MAP_ENTRIES    = MAP_ENTRIES_DEF,
    parameter int PHYS_ADDR_BITS = PHYS_ADDR_BITS_DEF
    )
    (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [PHYS_ADDR_BITS-1:0] cfg_data,
    pmt_in_if.sink                         in,
    pmt_out_if.source                      out
    );

    localparam int IDX_W = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
    localparam int HI_W  = PHYS_ADDR_BITS - HALF_W;

    // Configuration registers.
    logic                      map_enable_reg;
    logic [PHYS_ADDR_BITS-1:0] io_page_base_reg;

    // Map store: low and high halves, with a valid bit per half and entry.
    logic [HALF_W-1:0]      lo_mem [MAP_ENTRIES];
    logic [HI_W-1:0]        hi_mem [MAP_ENTRIES];
    logic [MAP_ENTRIES-1:0] lo_vld_reg;
    logic [MAP_ENTRIES-1:0] hi_vld_reg;

    // Request stage.
    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic [OPCODE_W-1:0] s1_op_reg;
    logic [BUS_W-1:0]    s1_addr_reg;
    logic                s1_hit_reg;
    logic                s1_top_reg;
    logic [HALF_W-1:0]   s1_lo_reg;
    logic [HI_W-1:0]     s1_hi_reg;
    logic                s1_lo_v_reg;
    logic                s1_hi_v_reg;

    // Result stage.
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [HALF_W-1:0]         rd_reg;
    logic [PHYS_ADDR_BITS-1:0] pa_reg;
    logic [HALF_W-1:0]         rd_next;
    logic [PHYS_ADDR_BITS-1:0] pa_next;

    // Handshake and request decode.
    logic             acc;
    logic             out_ld;
    logic             s1_free;
    logic [SEL_W-1:0] sel;
    logic [SEL_W-1:0] page;
    logic             high_half;
    logic             sel_hit;
    logic             page_hit;
    logic             wr_lo;
    logic             wr_hi;
    logic [IDX_W-1:0] widx;
    logic [IDX_W-1:0] ridx;
    logic             rhit;

    // ------------------------------------------------------------------
    // Handshake: the request stage moves on whenever the result register
    // is empty or being emptied in the same cycle.
    // ------------------------------------------------------------------
    assign out_ld   = s1_valid_reg && (!out_valid_reg || out.ready);
    assign s1_free  = !s1_valid_reg || out_ld;
    assign in.ready = s1_free;
    assign acc      = in.valid && s1_free;

    assign s1_valid_next  = acc ? 1'b1 : (out_ld ? 1'b0 : s1_valid_reg);
    assign out_valid_next = out_ld ? 1'b1 : (out.ready ? 1'b0 : out_valid_reg);

    // ------------------------------------------------------------------
    // Request decode. For map operations bits 6..2 select the register and
    // bit 1 the half; for a translate bits 17..13 give the page.
    // ------------------------------------------------------------------
    assign sel       = in.bus_address[6:2];
    assign high_half = in.bus_address[1];
    assign page      = in.bus_address[BUS_W-1:OFFSET_W];
    assign sel_hit   = 32'(sel) < 32'(MAP_ENTRIES);
    assign page_hit  = 32'(page) < 32'(MAP_ENTRIES);

    assign wr_lo = (in.opcode == OP_WRITE) && sel_hit && !high_half;
    assign wr_hi = (in.opcode == OP_WRITE) && sel_hit && high_half;
    assign widx  = IDX_W'(sel);

    // Only one item is accepted per cycle, so a single read address serves
    // both map reads and translates.
    assign ridx = (in.opcode == OP_READ) ? IDX_W'(sel) : IDX_W'(page);
    assign rhit = (in.opcode == OP_READ) ? sel_hit : page_hit;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_enable_reg   <= 1'b0;
            io_page_base_reg <= PHYS_ADDR_BITS'(IO_PAGE_BASE_RST);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAP_ENABLE:   map_enable_reg   <= cfg_data[0];
                CFG_IO_PAGE_BASE: io_page_base_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Map store. Bit 0 of the low half is always stored as zero; the high
    // half keeps only the bits that fit the physical address.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            if (wr_lo)
            begin
                lo_mem[widx] <= {in.write_data[HALF_W-1:1], 1'b0};
            end
            if (wr_hi)
            begin
                hi_mem[widx] <= in.write_data[HI_W-1:0];
            end
            s1_lo_reg <= lo_mem[ridx];
            s1_hi_reg <= hi_mem[ridx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_vld_reg <= '0;
            hi_vld_reg <= '0;
        end
        else if (acc)
        begin
            if (wr_lo)
            begin
                lo_vld_reg[widx] <= 1'b1;
            end
            if (wr_hi)
            begin
                hi_vld_reg[widx] <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Request stage.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_op_reg   <= in.opcode;
            s1_addr_reg <= in.bus_address;
            s1_hit_reg  <= rhit;
            s1_top_reg  <= (page == TOP_PAGE);
            s1_lo_v_reg <= rhit && lo_vld_reg[ridx];
            s1_hi_v_reg <= rhit && hi_vld_reg[ridx];
        end
    end

    // ------------------------------------------------------------------
    // Result stage: pick the base and add the page offset, or return the
    // requested half of a map register.
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [HALF_W-1:0]         base_lo;
        logic [HI_W-1:0]           base_hi;
        logic [PHYS_ADDR_BITS-1:0] base;

        base_lo = s1_lo_v_reg ? s1_lo_reg : '0;
        base_hi = s1_hi_v_reg ? s1_hi_reg : '0;
        base    = '0;
        rd_next = '0;
        pa_next = '0;

        case (s1_op_reg)
            OP_READ:
            begin
                if (s1_hit_reg)
                begin
                    rd_next = s1_addr_reg[1] ? (HALF_W'(base_hi) & HIGH_READ_MASK) : base_lo;
                end
            end
            OP_XLATE:
            begin
                if (!map_enable_reg)
                begin
                    pa_next = PHYS_ADDR_BITS'(s1_addr_reg);
                end
                else
                begin
                    if (s1_top_reg)
                    begin
                        base = io_page_base_reg;
                    end
                    else if (s1_hit_reg)
                    begin
                        base = {base_hi, base_lo};
                    end
                    pa_next = base + PHYS_ADDR_BITS'(s1_addr_reg[OFFSET_W-1:0]);
                end
            end
            default:
            begin
                rd_next = '0;
                pa_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (out_ld)
        begin
            rd_reg <= rd_next;
            pa_reg <= pa_next;
        end
    end

    assign out.valid            = out_valid_reg;
    assign out.read_data        = rd_reg;
    assign out.physical_address = pa_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // An accepted item always occupies the request stage in the next cycle.
    a_accept_to_stage: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> s1_valid_reg)
        else $error("accepted item did not reach the request stage");

    // The input side only stalls when both stages are full and the result
    // side is holding off.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in.ready |-> (s1_valid_reg && out_valid_reg && !out.ready))
        else $error("input stalled without a full pipeline");

    // A map write produces an all-zero result.
    a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_op_reg == OP_WRITE) |-> (rd_next == '0 && pa_next == '0))
        else $error("map write produced a non-zero result");

    // A result loaded into the output register is shown in the next cycle.
    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        out_ld |=> out.valid)
        else $error("loaded result not presented");

endmodule

`default_nettype wire
